[hw/rtl/rles_pkg.sv]
// Shared types and constants for the RGB LED effect sequencer.
// Holds the request/response item structs, mode and register codes, and timing constants.
// No dependencies.
package rles_pkg;

	// Request item: a tick or a timeout start
	typedef struct packed {
		logic        action;
		logic [31:0] now_ms;
		logic [2:0]  mode;
		logic [6:0]  battery_percent;
		logic [30:0] duration_ms;
	} req_t;

	// Response item: the pixel shown after the request
	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} rsp_t;

	// Action codes
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	// Effect modes
	localparam logic [2:0] MODE_ON      = 3'd0;
	localparam logic [2:0] MODE_OFF     = 3'd1;
	localparam logic [2:0] MODE_FADE    = 3'd2;
	localparam logic [2:0] MODE_BLINK   = 3'd3;
	localparam logic [2:0] MODE_BOOT    = 3'd4;
	localparam logic [2:0] MODE_BATTERY = 3'd5;
	localparam logic [2:0] MODE_TIMEOUT = 3'd6;
	localparam logic [2:0] MODE_HOLD    = 3'd7;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_SPEED  = 2'd3;

	localparam logic [7:0] FADE_SPEED_RESET = 8'd2;

	// Update periods in ms (update when elapsed time is strictly greater)
	localparam logic [31:0] FADE_PERIOD_MS  = 32'd10;
	localparam logic [31:0] BLINK_PERIOD_MS = 32'd500;

	// Step limits and boot ramp increment
	localparam logic signed [10:0] STEP_MAX  = 11'sd255;
	localparam logic signed [10:0] BOOT_STEP = 11'sd2;

	// Battery thresholds
	localparam logic [6:0] BATT_HIGH = 7'd75;
	localparam logic [6:0] BATT_MID  = 7'd50;
	localparam logic [6:0] BATT_LOW  = 7'd25;
	localparam logic [6:0] BATT_CRIT = 7'd5;

	// Battery palette components
	localparam logic [7:0] PAL_FULL   = 8'd255;
	localparam logic [7:0] PAL_ORANGE = 8'd165;
	localparam logic [7:0] PAL_RED_G  = 8'd40;

endpackage

[hw/rtl/rgb_led_effect_sequencer.sv]
// Top level of the RGB LED effect sequencer: input register, effect logic, pixel register.
// Depends on rles_pkg for item types, mode codes and constants.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: a tick that runs one
//   update of the selected effect, or a timeout start that records an end time.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one pixel per item.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the user color
//   and fade speed; cfg_ready is always high, write only while the block is idle.
// Path: an accepted item lands in the input register, and its pixel is then loaded
//   into the pixel register, which raises rsp_valid.
// Throughput: one item per cycle unless rsp stalls; the effect update is a single
//   pass through three 8x8 multipliers and a divide-by-255 correction between the
//   input and pixel registers, and effect state is written in that pass.
// Stall: while rsp is held off, the pixel register keeps its item; one more
//   item can wait in the input register, then req_ready drops.
// Reset (arst_n low): pixel off, step 0, direction up, times 0, color 0,
//   fade speed 2, both channels empty.
module rgb_led_effect_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  rles_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output rles_pkg::rsp_t                     rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rles_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_data
);

	// Exact x/255 for a 16-bit product of two 8-bit values
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	// Configuration registers
	logic [7:0] color_red_q, color_green_q, color_blue_q, fade_speed_q;

	// Effect state
	rles_pkg::rsp_t     pixel_q, pixel_d;
	logic signed [9:0]  step_q, step_d;
	logic               rising_q, rising_d;
	logic [31:0]        last_q, last_d;
	logic [31:0]        end_q, end_d;

	// Pipeline
	logic               valid_s1;
	rles_pkg::req_t     req_s1;
	logic               rsp_valid_q;
	logic               advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = pixel_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_red_q   <= 8'd0;
			color_green_q <= 8'd0;
			color_blue_q  <= 8'd0;
			fade_speed_q  <= rles_pkg::FADE_SPEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rles_pkg::REG_COLOR_RED:   color_red_q   <= cfg_data;
				rles_pkg::REG_COLOR_GREEN: color_green_q <= cfg_data;
				rles_pkg::REG_COLOR_BLUE:  color_blue_q  <= cfg_data;
				rles_pkg::REG_FADE_SPEED:  fade_speed_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Elapsed-time checks (wrapping difference)
	logic [31:0] elapsed;
	logic        fade_due, blink_due;
	assign elapsed   = req_s1.now_ms - last_q;
	assign fade_due  = elapsed > rles_pkg::FADE_PERIOD_MS;
	assign blink_due = elapsed > rles_pkg::BLINK_PERIOD_MS;

	// Fade update: move, clamp, scale the chosen color by step/255
	logic                battery_fade;
	logic [7:0]          fade_r, fade_g, fade_b;
	logic signed [10:0]  fade_delta, fade_sum;
	logic [7:0]          fade_step;
	logic                fade_rising;
	logic [15:0]         prod_r, prod_g, prod_b;
	rles_pkg::rsp_t      fade_pixel;

	assign battery_fade = req_s1.mode == rles_pkg::MODE_BATTERY;
	assign fade_r = battery_fade ? rles_pkg::PAL_FULL  : color_red_q;
	assign fade_g = battery_fade ? rles_pkg::PAL_RED_G : color_green_q;
	assign fade_b = battery_fade ? 8'd0                : color_blue_q;

	always_comb begin
		fade_delta = rising_q ? $signed({3'b000, fade_speed_q})
		                      : -$signed({3'b000, fade_speed_q});
		fade_sum   = $signed({step_q[9], step_q}) + fade_delta;
		if (fade_sum >= rles_pkg::STEP_MAX) begin
			fade_step   = 8'd255;
			fade_rising = 1'b0;
		end else if (fade_sum <= 11'sd0) begin
			fade_step   = 8'd0;
			fade_rising = 1'b1;
		end else begin
			fade_step   = fade_sum[7:0];
			fade_rising = rising_q;
		end
	end

	assign prod_r = fade_r * fade_step;
	assign prod_g = fade_g * fade_step;
	assign prod_b = fade_b * fade_step;
	assign fade_pixel = '{pixel_red: div255(prod_r), pixel_green: div255(prod_g),
	                      pixel_blue: div255(prod_b)};

	// Boot ramp: step +-2, direction flips at the ends, half truncates toward zero
	logic signed [10:0]  boot_sum, boot_half;
	logic                boot_rising;
	always_comb begin
		boot_sum    = $signed({step_q[9], step_q})
		            + (rising_q ? rles_pkg::BOOT_STEP : -rles_pkg::BOOT_STEP);
		boot_half   = (boot_sum + {10'd0, boot_sum[10]}) >>> 1;
		boot_rising = rising_q;
		if (boot_sum >= rles_pkg::STEP_MAX) boot_rising = 1'b0;
		if (boot_sum <= 11'sd0) boot_rising = 1'b1;
	end

	// Next-state selection
	rles_pkg::rsp_t user_pixel;
	assign user_pixel = '{pixel_red: color_red_q, pixel_green: color_green_q,
	                      pixel_blue: color_blue_q};

	always_comb begin
		pixel_d  = pixel_q;
		step_d   = step_q;
		rising_d = rising_q;
		last_d   = last_q;
		end_d    = end_q;
		if (req_s1.action == rles_pkg::ACT_TIMEOUT) begin
			end_d   = req_s1.now_ms + {1'b0, req_s1.duration_ms};
			pixel_d = user_pixel;
		end else begin
			case (req_s1.mode)
				rles_pkg::MODE_ON:  pixel_d = user_pixel;
				rles_pkg::MODE_OFF: pixel_d = '0;
				rles_pkg::MODE_FADE: begin
					if (fade_due) begin
						last_d   = req_s1.now_ms;
						step_d   = $signed({2'b00, fade_step});
						rising_d = fade_rising;
						pixel_d  = fade_pixel;
					end
				end
				rles_pkg::MODE_BLINK: begin
					if (blink_due) begin
						last_d = req_s1.now_ms;
						if (step_q == 10'sd0) begin
							step_d  = 10'sd1;
							pixel_d = user_pixel;
						end else begin
							step_d  = 10'sd0;
							pixel_d = '0;
						end
					end
				end
				rles_pkg::MODE_BOOT: begin
					if (fade_due) begin
						last_d   = req_s1.now_ms;
						step_d   = boot_sum[9:0];
						rising_d = boot_rising;
						pixel_d  = '{pixel_red: boot_half[7:0], pixel_green: boot_sum[7:0],
						             pixel_blue: 8'd0};
					end
				end
				rles_pkg::MODE_BATTERY: begin
					if (req_s1.battery_percent > rles_pkg::BATT_HIGH) begin
						pixel_d = '{pixel_red: 8'd0, pixel_green: rles_pkg::PAL_FULL,
						            pixel_blue: rles_pkg::PAL_FULL};
					end else if (req_s1.battery_percent > rles_pkg::BATT_MID) begin
						pixel_d = '{pixel_red: 8'd0, pixel_green: rles_pkg::PAL_FULL,
						            pixel_blue: 8'd0};
					end else if (req_s1.battery_percent > rles_pkg::BATT_LOW) begin
						pixel_d = '{pixel_red: rles_pkg::PAL_FULL,
						            pixel_green: rles_pkg::PAL_ORANGE, pixel_blue: 8'd0};
					end else if (req_s1.battery_percent > rles_pkg::BATT_CRIT) begin
						pixel_d = '{pixel_red: rles_pkg::PAL_FULL,
						            pixel_green: rles_pkg::PAL_RED_G, pixel_blue: 8'd0};
					end else if (fade_due) begin
						last_d   = req_s1.now_ms;
						step_d   = $signed({2'b00, fade_step});
						rising_d = fade_rising;
						pixel_d  = fade_pixel;
					end
				end
				rles_pkg::MODE_TIMEOUT: begin
					if (req_s1.now_ms >= end_q) pixel_d = '0;
					else pixel_d = user_pixel;
				end
				rles_pkg::MODE_HOLD: ;
				default: ;
			endcase
		end
	end

	// Effect state and pixel (result) register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q     <= '0;
			step_q      <= 10'sd0;
			rising_q    <= 1'b1;
			last_q      <= 32'd0;
			end_q       <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pixel_q  <= pixel_d;
				step_q   <= step_d;
				rising_q <= rising_d;
				last_q   <= last_d;
				end_q    <= end_d;
			end
			if (advance) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// Accepted item always reaches the input register
	a_req_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("accepted item did not reach input register");

	// A waiting item in the input register is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("input register lost a waiting item");

	// Effect state only moves when an item is processed
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(step_q) && $stable(last_q) && $stable(end_q) && $stable(pixel_q))
		else $error("effect state changed without an item");

	// A processed fade tick leaves the step clamped to 0..255
	a_fade_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.action == rles_pkg::ACT_TICK && req_s1.mode == rles_pkg::MODE_FADE
		&& fade_due |=> step_q >= 10'sd0 && step_q <= 10'sd255)
		else $error("fade step out of range");

	// Timeout start records now plus duration
	a_timeout_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.action == rles_pkg::ACT_TIMEOUT
		|=> end_q == $past(req_s1.now_ms + {1'b0, req_s1.duration_ms}))
		else $error("timeout end time not recorded");

endmodule

[tb/sv/tb_rgb_led_effect_sequencer.sv]
// Self-checking testbench for rgb_led_effect_sequencer: directed and random ticks and
// timeout starts, with an in-bench pixel predictor and per-field result checks.
// Depends on rles_pkg and the rgb_led_effect_sequencer RTL.
`timescale 1ns / 1ps

module tb_rgb_led_effect_sequencer;

	localparam int CLK_HALF         = 6;
	localparam int RESET_CYCLES     = 7;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int WATCHDOG_CYCLES  = 400_000;
	localparam int MAX_PRINTED      = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	rles_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rles_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [rles_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	// Predicted block state and register copies
	logic [7:0]        user_r, user_g, user_b, fade_spd;
	rles_pkg::rsp_t    led_px;
	logic signed [9:0] led_step;
	logic              led_up;
	logic [31:0]       led_last;
	logic [31:0]       led_end;

	rles_pkg::rsp_t pending_pixels[$];
	logic [31:0] t_ms;
	int          err_cnt   = 0;
	int          items_sent = 0;
	int          checked   = 0;
	int          cfg_loads = 0;
	bit          idle_on   = 1'b1;
	bit          hold_rsp  = 1'b0;

	rgb_led_effect_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void show_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		led_px = '{pixel_red: r, pixel_green: g, pixel_blue: b};
	endfunction

	// Fade one update, clamped to 0..255, pixel scaled by step/255
	function automatic void fade_update(logic [31:0] at_ms, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		logic [31:0] dt;
		int s;
		dt = at_ms - led_last;
		if (dt <= rles_pkg::FADE_PERIOD_MS)
			return;
		led_last = at_ms;
		s = int'(led_step) + (led_up ? int'(fade_spd) : -int'(fade_spd));
		if (s >= 255) begin
			led_up = 1'b0;
			s = 255;
		end else if (s <= 0) begin
			led_up = 1'b1;
			s = 0;
		end
		led_step = s[9:0];
		show_px(8'((int'(r) * s) / 255), 8'((int'(g) * s) / 255), 8'((int'(b) * s) / 255));
	endfunction

	// Boot ramp: no clamping, step may leave 0..255 by one increment
	function automatic void boot_update(logic [31:0] at_ms);
		logic [31:0] dt;
		int s;
		int half;
		dt = at_ms - led_last;
		if (dt <= rles_pkg::FADE_PERIOD_MS)
			return;
		led_last = at_ms;
		s = int'(led_step) + (led_up ? 2 : -2);
		if (s >= 255)
			led_up = 1'b0;
		if (s <= 0)
			led_up = 1'b1;
		led_step = s[9:0];
		half = s / 2;
		show_px(8'(half), 8'(s), 8'd0);
	endfunction

	function automatic void blink_update(logic [31:0] at_ms);
		logic [31:0] dt;
		dt = at_ms - led_last;
		if (dt <= rles_pkg::BLINK_PERIOD_MS)
			return;
		led_last = at_ms;
		led_step = (led_step == 10'sd0) ? 10'sd1 : 10'sd0;
		if (led_step != 10'sd0)
			show_px(user_r, user_g, user_b);
		else
			show_px(8'd0, 8'd0, 8'd0);
	endfunction

	// Applies one item to the predicted state, returns the pixel shown after it
	function automatic rles_pkg::rsp_t advance_led(rles_pkg::req_t it);
		if (it.action == rles_pkg::ACT_TIMEOUT) begin
			led_end = it.now_ms + 32'(it.duration_ms);
			show_px(user_r, user_g, user_b);
		end else begin
			case (it.mode)
				rles_pkg::MODE_ON:    show_px(user_r, user_g, user_b);
				rles_pkg::MODE_OFF:   show_px(8'd0, 8'd0, 8'd0);
				rles_pkg::MODE_FADE:  fade_update(it.now_ms, user_r, user_g, user_b);
				rles_pkg::MODE_BLINK: blink_update(it.now_ms);
				rles_pkg::MODE_BOOT:  boot_update(it.now_ms);
				rles_pkg::MODE_BATTERY: begin
					if (it.battery_percent > rles_pkg::BATT_HIGH)
						show_px(8'd0, rles_pkg::PAL_FULL, rles_pkg::PAL_FULL);
					else if (it.battery_percent > rles_pkg::BATT_MID)
						show_px(8'd0, rles_pkg::PAL_FULL, 8'd0);
					else if (it.battery_percent > rles_pkg::BATT_LOW)
						show_px(rles_pkg::PAL_FULL, rles_pkg::PAL_ORANGE, 8'd0);
					else if (it.battery_percent > rles_pkg::BATT_CRIT)
						show_px(rles_pkg::PAL_FULL, rles_pkg::PAL_RED_G, 8'd0);
					else
						fade_update(it.now_ms, rles_pkg::PAL_FULL, rles_pkg::PAL_RED_G, 8'd0);
				end
				rles_pkg::MODE_TIMEOUT: begin
					if (it.now_ms >= led_end)
						show_px(8'd0, 8'd0, 8'd0);
					else
						show_px(user_r, user_g, user_b);
				end
				default: ;  // hold
			endcase
		end
		return led_px;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTED)
			$display("MISMATCH: %s", msg);
	endtask

	always @(posedge clk) begin : check_results
		rles_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel %h with no item pending", rsp));
			end else begin
				want = pending_pixels.pop_front();
				checked++;
				if (rsp.pixel_red !== want.pixel_red)
					report_mismatch($sformatf("result %0d red %h, expected %h",
						checked, rsp.pixel_red, want.pixel_red));
				if (rsp.pixel_green !== want.pixel_green)
					report_mismatch($sformatf("result %0d green %h, expected %h",
						checked, rsp.pixel_green, want.pixel_green));
				if (rsp.pixel_blue !== want.pixel_blue)
					report_mismatch($sformatf("result %0d blue %h, expected %h",
						checked, rsp.pixel_blue, want.pixel_blue));
			end
		end
	end

	// Result side: random stall bursts, or one long hold-off when asked
	initial begin : rsp_side
		rsp_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// Valid stays high between back-to-back items; it drops only for a gap
	task automatic send_item(rles_pkg::req_t it);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		pending_pixels.push_back(advance_led(it));
		items_sent++;
	endtask

	task automatic wait_results();
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic tick(logic [2:0] m, logic [6:0] lvl);
		rles_pkg::req_t it;
		it.action = rles_pkg::ACT_TICK;
		it.now_ms = t_ms;
		it.mode = m;
		it.battery_percent = lvl;
		it.duration_ms = 31'($urandom);
		send_item(it);
	endtask

	task automatic start_timeout(logic [30:0] dur);
		rles_pkg::req_t it;
		it.action = rles_pkg::ACT_TIMEOUT;
		it.now_ms = t_ms;
		it.mode = 3'($urandom);
		it.battery_percent = 7'($urandom);
		it.duration_ms = dur;
		send_item(it);
	endtask

	task automatic write_reg(logic [rles_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rles_pkg::REG_COLOR_RED:   user_r = val;
			rles_pkg::REG_COLOR_GREEN: user_g = val;
			rles_pkg::REG_COLOR_BLUE:  user_b = val;
			rles_pkg::REG_FADE_SPEED:  fade_spd = val;
			default: ;
		endcase
	endtask

	// Registers change only with nothing in flight
	task automatic load_cfg(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] spd);
		wait_results();
		write_reg(rles_pkg::REG_COLOR_RED, r);
		write_reg(rles_pkg::REG_COLOR_GREEN, g);
		write_reg(rles_pkg::REG_COLOR_BLUE, b);
		write_reg(rles_pkg::REG_FADE_SPEED, spd);
		cfg_valid <= 1'b0;
		cfg_loads++;
	endtask

	// Mostly runs of one effect with advancing time, plus timeouts, wraps and noise
	task automatic run_random(int n);
		int stop_at;
		int len;
		int dt_max;
		bit crit;
		logic [2:0] m;
		rles_pkg::req_t it;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: begin
					it.action = 1'($urandom);
					it.now_ms = $urandom;
					it.mode = 3'($urandom);
					it.battery_percent = 7'($urandom);
					it.duration_ms = 31'($urandom);
					t_ms = it.now_ms;
					send_item(it);
				end
				1: begin
					start_timeout(($urandom_range(0, 3) == 0) ? 31'($urandom)
						: 31'($urandom_range(0, 300)));
					len = $urandom_range(3, 8);
					repeat (len) begin
						t_ms += $urandom_range(0, 100);
						tick(rles_pkg::MODE_TIMEOUT, 7'($urandom));
					end
				end
				2: t_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
				default: begin
					case ($urandom_range(0, 9))
						0, 1:    m = rles_pkg::MODE_FADE;
						2, 3:    m = rles_pkg::MODE_BOOT;
						4:       m = rles_pkg::MODE_BLINK;
						5, 6:    m = rles_pkg::MODE_BATTERY;
						7:       m = rles_pkg::MODE_ON;
						8:       m = rles_pkg::MODE_OFF;
						default: m = rles_pkg::MODE_HOLD;
					endcase
					len = (m == rles_pkg::MODE_BOOT) ? $urandom_range(4, 40)
						: $urandom_range(4, 20);
					dt_max = (m == rles_pkg::MODE_BLINK) ? 800 : 25;
					crit = 1'($urandom);
					repeat (len) begin
						t_ms += $urandom_range(0, dt_max);
						tick(m, crit ? 7'($urandom_range(0, 5)) : 7'($urandom));
					end
				end
			endcase
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_reset_values();
		t_ms = 32'd0;
		tick(rles_pkg::MODE_HOLD, 7'd0);
		tick(rles_pkg::MODE_ON, 7'd0);
		tick(rles_pkg::MODE_TIMEOUT, 7'd0);   // end time is zero after reset
		t_ms = 32'd5;
		tick(rles_pkg::MODE_FADE, 7'd0);      // too soon for an update
	endtask

	task automatic test_directed_cases();
		logic [6:0] levels[7] = '{7'd76, 7'd75, 7'd51, 7'd50, 7'd26, 7'd25, 7'd6};
		load_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		t_ms = 32'd1000;
		tick(rles_pkg::MODE_ON, 7'd0);
		tick(rles_pkg::MODE_OFF, 7'd127);
		tick(rles_pkg::MODE_FADE, 7'd0);                  // jumps to the top and clamps
		t_ms += 10; tick(rles_pkg::MODE_FADE, 7'd0);      // exactly one period: no update
		t_ms += 1;  tick(rles_pkg::MODE_FADE, 7'd0);      // clamps at zero, turns up
		t_ms += 11; tick(rles_pkg::MODE_FADE, 7'd0);      // top again, now counting down
		t_ms += 500; tick(rles_pkg::MODE_BLINK, 7'd0);    // exactly the blink period
		t_ms += 1;  tick(rles_pkg::MODE_BLINK, 7'd0);     // step to 0, direction still down
		t_ms += 11; tick(rles_pkg::MODE_BOOT, 7'd0);      // boot goes below zero
		t_ms += 11; tick(rles_pkg::MODE_BOOT, 7'd0);
		foreach (levels[i]) begin
			t_ms += 1;
			tick(rles_pkg::MODE_BATTERY, levels[i]);
		end
		t_ms += 11; tick(rles_pkg::MODE_BATTERY, 7'd5);   // critical level runs the fade
		t_ms += 11; tick(rles_pkg::MODE_BATTERY, 7'd0);
		// end time wraps past 2^32
		t_ms = 32'hFFFF_FFFF;
		start_timeout(31'h7FFF_FFFF);
		t_ms = 32'h7FFF_FFFD; tick(rles_pkg::MODE_TIMEOUT, 7'd0);
		t_ms = 32'h7FFF_FFFE; tick(rles_pkg::MODE_TIMEOUT, 7'd0);
		// fade timer across the time wrap
		t_ms = 32'hFFFF_FFFA; tick(rles_pkg::MODE_FADE, 7'd0);
		t_ms = 32'd4;         tick(rles_pkg::MODE_FADE, 7'd0);
		t_ms = 32'd5;         tick(rles_pkg::MODE_FADE, 7'd0);
	endtask

	// Long result hold-off while items keep coming, so the input side backs up
	task automatic test_output_stall();
		load_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'd17);
		hold_rsp = 1'b1;
		repeat (16) begin
			t_ms += $urandom_range(0, 25);
			tick(rles_pkg::MODE_FADE, 7'($urandom));
		end
		wait_results();
	endtask

	task automatic test_random_settings();
		load_cfg(8'd0, 8'd0, 8'd0, 8'd0);
		run_random(130);
		load_cfg(8'hFF, 8'hFF, 8'hFF, 8'd1);
		run_random(130);
		load_cfg(8'hFF, 8'd0, 8'h80, 8'hFF);
		run_random(130);
		load_cfg(8'd1, 8'd2, 8'd3, rles_pkg::FADE_SPEED_RESET);
		run_random(130);
		repeat (3) begin
			load_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 40)));
			run_random(130);
		end
	endtask

	task automatic test_back_to_back();
		load_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		idle_on = 1'b0;
		run_random(100);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : main_seq
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		user_r = 8'd0;
		user_g = 8'd0;
		user_b = 8'd0;
		fade_spd = rles_pkg::FADE_SPEED_RESET;
		led_px = '0;
		led_step = 10'sd0;
		led_up = 1'b1;
		led_last = 32'd0;
		led_end = 32'd0;
		t_ms = 32'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_cases();
		test_output_stall();
		test_random_settings();
		test_back_to_back();

		wait_results();
		repeat (4) @(posedge clk);
		$display("Ran %0d items, checked %0d pixels over %0d register settings.",
			items_sent, checked, cfg_loads);
		$display("Included a %0d-cycle result stall and a stretch with no idling.",
			LONG_HOLD_CYCLES);
		if (err_cnt == 0 && pending_pixels.size() == 0)
			$display("rgb_led_effect_sequencer regression: pass");
		else
			$display("rgb_led_effect_sequencer regression: fail");
		$finish;
	end

	initial begin : watchdog
		#(WATCHDOG_CYCLES * 2 * CLK_HALF);
		$display("rgb_led_effect_sequencer regression: fail");
		$finish;
	end

endmodule
